>>> rtl/assert_macros.svh
// assertion helpers used by the ils_checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> rtl/ils_pkg.sv
`default_nettype none

package ils_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // transaction field widths
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 5;
   localparam int PEND_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // request functions
   localparam logic [FUNC_W-1:0] F_READ   = 3'd0;
   localparam logic [FUNC_W-1:0] F_WRITE  = 3'd1;
   localparam logic [FUNC_W-1:0] F_INSERT = 3'd2;
   localparam logic [FUNC_W-1:0] F_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] F_RANGE  = 3'd4;
   localparam logic [FUNC_W-1:0] F_PUSH   = 3'd5;
   localparam logic [FUNC_W-1:0] F_POP    = 3'd6;
   localparam logic [FUNC_W-1:0] F_CLEAR  = 3'd7;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

   // what every cell of the row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

endpackage

`default_nettype wire

>>> rtl/ils_req_if.sv
`default_nettype none

interface ils_req_if;
   import ils_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [POS_W-1:0]    position;
   logic [PEND_W-1:0]   position_end;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, func, position, position_end, value, input ready);
   modport sink   (input valid, func, position, position_end, value, output ready);
endinterface

`default_nettype wire

>>> rtl/ils_rsp_if.sv
`default_nettype none

interface ils_rsp_if;
   import ils_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   read_data;
   logic [COUNT_W-1:0]   count;
   logic                 empty_res;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, read_data, count, empty_res, status, input ready);
   modport sink   (input valid, read_data, count, empty_res, status, output ready);
endinterface

`default_nettype wire

>>> rtl/ils_cell.sv
`default_nettype none

module ils_cell #(
   parameter int DATA_W = 32,
   parameter int IDX_W  = 4,
   parameter int INDEX  = 0
) (
   input  wire logic                clock,
   input  wire ils_pkg::cell_op_type op,
   input  wire logic [IDX_W-1:0]    pos,
   input  wire logic [DATA_W-1:0]   value,
   input  wire logic [DATA_W-1:0]   left_data,
   input  wire logic [DATA_W-1:0]   right_data,
   output logic      [DATA_W-1:0]   data,
   output logic      [DATA_W-1:0]   sel_data
);
   import ils_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              hit;
   logic              above;

   assign hit   = (pos == MY_IDX);
   assign above = (MY_IDX > pos);

   always_comb begin
      case (op)
         CELL_WRITE:  data_in = hit ? value : data_ff;
         // entries at and past the slot move up one cell
         CELL_INSERT: data_in = hit ? value : (above ? left_data : data_ff);
         // entries past the slot move down one cell
         CELL_REMOVE: data_in = (hit || above) ? right_data : data_ff;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = hit ? data_ff : '0;

endmodule

`default_nettype wire

>>> rtl/ils_row.sv
`default_nettype none

module ils_row #(
   parameter int CAPACITY = 16,
   parameter int DATA_W   = 32
) (
   input  wire logic                         clock,
   input  wire ils_pkg::cell_op_type         op,
   input  wire logic [$clog2(CAPACITY)-1:0]  pos,
   input  wire logic [DATA_W-1:0]            value,
   output logic      [DATA_W-1:0]            rd_data
);
   import ils_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_sel  [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_left
         assign left_d = cell_data[i-1];
      end

      // last cell keeps its own word on a remove
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_right
         assign right_d = cell_data[i+1];
      end

      ils_cell #(
         .DATA_W (DATA_W),
         .IDX_W  (IDX_W),
         .INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (pos),
         .value      (value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .sel_data   (cell_sel[i])
      );
   end

   // at most one cell matches, so an or of all selects gives the read word
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | cell_sel[i];
      end
   end

endmodule

`default_nettype wire

>>> rtl/indexed_list_store.sv
// Ordered list of up to CAPACITY words held in a row of cells, with a live
// count. A request reads or writes the entry at a position, inserts or
// removes at a position (later entries move by one cell), removes an
// inclusive range, pushes or pops at the end, or clears the list; each
// request returns one response with the read word, the count after the
// operation, an empty flag and a status (ok, full, bad position). A range
// removal takes out the entries from position through position_end, one
// entry per pass, because the row shifts by one cell a pass; no other
// request is taken while its passes go on. The response is registered and
// appears the cycle after the last pass; a new request is taken while a
// response waits only if that response is taken in the same cycle.
// Stored words are not reset and only entries below the count are readable.
`default_nettype none

module indexed_list_store #(
   parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ils_req_if.sink      req_chan,
   ils_rsp_if.source    rsp_chan
);
   import ils_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               respond;
   cell_op_type        cell_op;
   logic [IDX_W-1:0]   cell_pos;
   logic [DATA_WIDTH-1:0] cell_value;
   logic [DATA_WIDTH-1:0] rd_word;

   logic [CMP_W-1:0]   pos_w, pend_w, cnt_w;
   logic               pos_lt, pos_le, is_full, range_ok;
   logic [STATUS_W-1:0] status;
   logic               rd_ok;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_w    = CMP_W'(req_chan.position);
   assign pend_w   = CMP_W'(req_chan.position_end);
   assign cnt_w    = CMP_W'(count_ff);
   assign pos_lt   = (pos_w < cnt_w);
   assign pos_le   = (pos_w <= cnt_w);
   assign is_full  = (count_ff == CNT_FULL);
   assign range_ok = (pos_w <= pend_w) && (pend_w < cnt_w);

   assign cell_value = DATA_WIDTH'(req_chan.value);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      cell_op  = CELL_HOLD;
      cell_pos = IDX_W'(req_chan.position);
      status   = ST_OK;
      rd_ok    = 1'b0;
      respond  = 1'b0;

      if (state_ff == ST_RANGE) begin
         // one entry of the range leaves the row per pass
         cell_op  = CELL_REMOVE;
         cell_pos = pos_ff;
         count_in = count_ff - CNT_ONE;
         rem_in   = rem_ff - CNT_ONE;
         if (rem_ff == CNT_ONE) begin
            state_in = ST_IDLE;
            respond  = 1'b1;
         end
      end else if (accept) begin
         respond = 1'b1;
         case (req_chan.func)
            F_READ: begin
               if (pos_lt) rd_ok = 1'b1;
               else        status = ST_BADPOS;
            end
            F_WRITE: begin
               if (pos_lt) cell_op = CELL_WRITE;
               else        status = ST_BADPOS;
            end
            F_INSERT: begin
               if (!pos_le) begin
                  status = ST_BADPOS;
               end else if (is_full) begin
                  status = ST_FULL;
               end else begin
                  cell_op  = CELL_INSERT;
                  count_in = count_ff + CNT_ONE;
               end
            end
            F_REMOVE: begin
               if (pos_lt) begin
                  cell_op  = CELL_REMOVE;
                  count_in = count_ff - CNT_ONE;
               end else begin
                  status = ST_BADPOS;
               end
            end
            F_RANGE: begin
               if (range_ok) begin
                  cell_op  = CELL_REMOVE;
                  count_in = count_ff - CNT_ONE;
                  rem_in   = CNT_W'(pend_w - pos_w);
                  pos_in   = IDX_W'(req_chan.position);
                  if (pend_w != pos_w) begin
                     state_in = ST_RANGE;
                     respond  = 1'b0;
                  end
               end else begin
                  status = ST_BADPOS;
               end
            end
            F_PUSH: begin
               if (is_full) begin
                  status = ST_FULL;
               end else begin
                  cell_op  = CELL_WRITE;
                  cell_pos = IDX_W'(count_ff);
                  count_in = count_ff + CNT_ONE;
               end
            end
            F_POP: begin
               if (count_ff != '0) count_in = count_ff - CNT_ONE;
            end
            F_CLEAR: begin
               count_in = '0;
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   ils_row #(
      .CAPACITY (CAPACITY),
      .DATA_W   (DATA_WIDTH)
   ) u_row (
      .clock   (clock),
      .op      (cell_op),
      .pos     (cell_pos),
      .value   (cell_value),
      .rd_data (rd_word)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (respond) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = rd_ok ? VALUE_W'(rd_word) : '0;
         rsp_count_in  = COUNT_W'(count_in);
         rsp_empty_in  = (count_in == '0);
         rsp_status_in = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/ils_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ils_checker #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ils_pkg::VALUE_W-1:0]   rsp_read_data,
   input wire logic [ils_pkg::COUNT_W-1:0]   rsp_count,
   input wire logic                          rsp_empty_res,
   input wire logic [ils_pkg::STATUS_W-1:0]  rsp_status
);
   import ils_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);

   // a pending response stays until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready), rsp_valid)

   // empty flag and count agree when the list fits the count field
   `ASSERT_IMPLY(a_empty_count, clock, reset, (rsp_valid && (CAPACITY < 32)), (rsp_empty_res == (rsp_count == '0)))

   // a full rejection only happens at capacity
   `ASSERT_IMPLY(a_full_count, clock, reset, (rsp_valid && (rsp_status == ST_FULL)), (rsp_count == COUNT_FULL))

   // a rejected transaction returns no data
   `ASSERT_IMPLY(a_bad_no_data, clock, reset, (rsp_valid && (rsp_status != ST_OK)), (rsp_read_data == '0))

endmodule

bind indexed_list_store ils_checker #(
   .CAPACITY (CAPACITY)
) u_ils_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_count     (rsp_chan.count),
   .rsp_empty_res (rsp_chan.empty_res),
   .rsp_status    (rsp_chan.status)
);

`default_nettype wire

>>> test/ils_response_checker.sv
`timescale 1ns / 100ps

module ils_response_checker
   import ils_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ils_req_if   req_mon,
   ils_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending,
   output int   ok_count,
   output int   full_count,
   output int   badpos_count
);

   localparam int LIST_CAP = CAPACITY_DEF;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_data;
      logic [COUNT_W-1:0]  count;
      logic                empty_res;
      logic [STATUS_W-1:0] status;
   } list_rsp_type;

   // shadow of the list held by the block
   logic [VALUE_W-1:0] shadow_words [LIST_CAP];
   int                 shadow_len;
   list_rsp_type       expected_rsp_q [$];

   // applies one request to the shadow list and returns the response it should give
   function automatic list_rsp_type apply_list_op(input logic [FUNC_W-1:0] func,
                                                  input logic [POS_W-1:0] position,
                                                  input logic [PEND_W-1:0] position_end,
                                                  input logic [VALUE_W-1:0] value);
      list_rsp_type rsp;
      int           pos;
      int           pend;
      int           gap;
      int           idx;
      pos = int'(position);
      pend = int'(position_end);
      rsp = '0;
      rsp.status = ST_OK;
      case (func)
         F_READ: begin
            if (pos < shadow_len) rsp.read_data = shadow_words[pos];
            else rsp.status = ST_BADPOS;
         end
         F_WRITE: begin
            if (pos < shadow_len) shadow_words[pos] = value;
            else rsp.status = ST_BADPOS;
         end
         F_INSERT: begin
            // position check wins over the full check
            if (pos > shadow_len) begin
               rsp.status = ST_BADPOS;
            end else if (shadow_len >= LIST_CAP) begin
               rsp.status = ST_FULL;
            end else begin
               for (idx = shadow_len; idx > pos; idx--)
                  shadow_words[idx] = shadow_words[idx-1];
               shadow_words[pos] = value;
               shadow_len++;
            end
         end
         F_REMOVE: begin
            if (pos < shadow_len) begin
               for (idx = pos; idx + 1 < shadow_len; idx++)
                  shadow_words[idx] = shadow_words[idx+1];
               shadow_len--;
            end else begin
               rsp.status = ST_BADPOS;
            end
         end
         F_RANGE: begin
            if (pos <= pend && pend < shadow_len) begin
               gap = pend - pos + 1;
               for (idx = pos; idx + gap < shadow_len; idx++)
                  shadow_words[idx] = shadow_words[idx+gap];
               shadow_len -= gap;
            end else begin
               rsp.status = ST_BADPOS;
            end
         end
         F_PUSH: begin
            if (shadow_len >= LIST_CAP) begin
               rsp.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = value;
               shadow_len++;
            end
         end
         F_POP: begin
            if (shadow_len > 0) shadow_len--;
         end
         F_CLEAR: begin
            shadow_len = 0;
         end
         default: ;
      endcase
      rsp.count = COUNT_W'(shadow_len);
      rsp.empty_res = (shadow_len == 0);
      return rsp;
   endfunction

   task automatic compare_field(input string field_name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field_name, exp_val, act_val);
      end
   endtask

   initial begin
      error_count = 0;
      pending = 0;
      ok_count = 0;
      full_count = 0;
      badpos_count = 0;
      shadow_len = 0;
      foreach (shadow_words[i]) shadow_words[i] = '0;
   end

   always @(posedge clock) begin
      list_rsp_type exp_rsp;
      if (reset) begin
         shadow_len = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               $display("%0t ns: response with none expected, expected nothing, actual %0h",
                        $time, {rsp_mon.read_data, rsp_mon.count, rsp_mon.empty_res,
                                rsp_mon.status});
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               compare_field("read_data", 32'(exp_rsp.read_data), 32'(rsp_mon.read_data));
               compare_field("count", 32'(exp_rsp.count), 32'(rsp_mon.count));
               compare_field("empty_res", 32'(exp_rsp.empty_res), 32'(rsp_mon.empty_res));
               compare_field("status", 32'(exp_rsp.status), 32'(rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            exp_rsp = apply_list_op(req_mon.func, req_mon.position, req_mon.position_end,
                                    req_mon.value);
            case (exp_rsp.status)
               ST_OK:   ok_count++;
               ST_FULL: full_count++;
               default: badpos_count++;
            endcase
            expected_rsp_q.push_back(exp_rsp);
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

>>> test/tb_indexed_list_store.sv
`timescale 1ns / 100ps

module tb_indexed_list_store;
   import ils_pkg::*;

   localparam int LIST_CAP     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 2000;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_WAIT  = 40;
   localparam int HOLD_CYCLES  = 200;

   typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } traffic_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ils_req_if req_if ();
   ils_rsp_if rsp_if ();

   int error_count;
   int pending;
   int ok_count;
   int full_count;
   int badpos_count;

   int list_len = 0;
   int peak_len = 0;
   int sent_count = 0;
   int rsp_taken = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit sender_burst = 1'b0;

   indexed_list_store dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   ils_response_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .error_count  (error_count),
      .pending      (pending),
      .ok_count     (ok_count),
      .full_count   (full_count),
      .badpos_count (badpos_count)
   );

   always #2 clock = ~clock;

   // list length after a request, used to steer positions and modes and to track the peak length
   function automatic int len_after(input logic [FUNC_W-1:0] f, input int p, input int e,
                                    input int len);
      case (f)
         F_INSERT: return (p <= len && len < LIST_CAP) ? len + 1 : len;
         F_REMOVE: return (p < len) ? len - 1 : len;
         F_RANGE:  return (p <= e && e < len) ? len - (e - p + 1) : len;
         F_PUSH:   return (len < LIST_CAP) ? len + 1 : len;
         F_POP:    return (len > 0) ? len - 1 : len;
         F_CLEAR:  return 0;
         default:  return len;
      endcase
   endfunction

   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                               input logic [PEND_W-1:0] e, input logic [VALUE_W-1:0] v);
      int gap;
      gap = (sender_burst || hold_off) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= f;
      req_if.position     <= p;
      req_if.position_end <= e;
      req_if.value        <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      list_len = len_after(f, int'(p), int'(e), list_len);
      if (list_len > peak_len) peak_len = list_len;
      sent_count++;
   endtask

   task automatic random_request(input traffic_mode_type mode);
      logic [FUNC_W-1:0]  f;
      logic [POS_W-1:0]   p;
      logic [PEND_W-1:0]  e;
      logic [VALUE_W-1:0] v;
      int                 r;
      int                 hi;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         f = F_CLEAR;
      end else begin
         r = $urandom_range(0, 99);
         case (mode)
            MODE_GROW:
               f = (r < 35) ? F_PUSH : (r < 70) ? F_INSERT : (r < 85) ? F_WRITE : F_READ;
            MODE_SHRINK:
               f = (r < 30) ? F_REMOVE : (r < 60) ? F_RANGE : (r < 80) ? F_POP : F_READ;
            default:
               f = FUNC_W'($urandom_range(0, 6));
         endcase
      end
      // mostly positions among the live entries, sometimes anywhere in the field
      if ($urandom_range(0, 9) < 8) begin
         if (f == F_INSERT) p = POS_W'($urandom_range(0, list_len));
         else p = POS_W'((list_len > 0) ? $urandom_range(0, list_len - 1) : 0);
      end else begin
         p = POS_W'($urandom_range(0, 31));
      end
      r = $urandom_range(0, 9);
      if (f == F_RANGE && list_len > 0 && r == 0) begin
         p = '0;
         e = PEND_W'(list_len - 1);
      end else if (f == F_RANGE && list_len > 0 && r < 8 && int'(p) < list_len) begin
         hi = int'(p) + $urandom_range(0, 3);
         e = PEND_W'((hi > list_len - 1) ? list_len - 1 : hi);
      end else begin
         e = PEND_W'($urandom_range(0, 15));
      end
      r = $urandom_range(0, 9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_W'($urandom);
      send_request(f, p, e, v);
   endtask

   // stimulus
   initial begin
      traffic_mode_type mode;
      int               run_len;
      req_if.valid        <= 1'b0;
      req_if.func         <= F_READ;
      req_if.position     <= '0;
      req_if.position_end <= '0;
      req_if.value        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corner cases
      send_request(F_READ,   5'd0,  4'd0,  32'h0);
      send_request(F_POP,    5'd0,  4'd0,  32'h0);
      send_request(F_WRITE,  5'd0,  4'd0,  32'hdeadbeef);
      send_request(F_REMOVE, 5'd0,  4'd0,  32'h0);
      send_request(F_RANGE,  5'd0,  4'd0,  32'h0);
      send_request(F_INSERT, 5'd1,  4'd0,  32'h11111111);
      // build a short list through front, end and middle inserts
      send_request(F_INSERT, 5'd0,  4'd0,  32'hffffffff);
      send_request(F_PUSH,   5'd0,  4'd0,  32'h00000000);
      send_request(F_INSERT, 5'd1,  4'd0,  32'ha5a5a5a5);
      send_request(F_INSERT, 5'd3,  4'd0,  32'h12345678);
      send_request(F_READ,   5'd0,  4'd0,  32'h0);
      send_request(F_READ,   5'd3,  4'd0,  32'h0);
      send_request(F_WRITE,  5'd2,  4'd0,  32'h5a5a5a5a);
      send_request(F_READ,   5'd2,  4'd0,  32'h0);
      send_request(F_READ,   5'd31, 4'd15, 32'h0);
      // ranges past the count and reversed ranges are refused
      send_request(F_RANGE,  5'd0,  4'd15, 32'h0);
      send_request(F_RANGE,  5'd2,  4'd1,  32'h0);
      send_request(F_REMOVE, 5'd1,  4'd0,  32'h0);
      send_request(F_RANGE,  5'd0,  4'd1,  32'h0);
      send_request(F_READ,   5'd0,  4'd0,  32'h0);
      send_request(F_CLEAR,  5'd0,  4'd0,  32'h0);
      send_request(F_READ,   5'd0,  4'd0,  32'h0);

      while (sent_count < RANDOM_ITEMS + 22) begin
         mode = traffic_mode_type'($urandom_range(0, 2));
         // a full list gets emptied more often, an empty one filled
         if (list_len >= LIST_CAP - 2 && $urandom_range(0, 1) == 0) mode = MODE_SHRINK;
         if (list_len <= 2 && $urandom_range(0, 1) == 0) mode = MODE_GROW;
         sender_burst = ($urandom_range(0, 3) == 0);
         run_len = $urandom_range(10, 50);
         repeat (run_len) random_request(mode);
      end
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("%0d requests sent, directed empty-list and shift cases then random traffic",
               sent_count);
      $display("responses: %0d ok, %0d full, %0d bad position; list peaked at %0d entries",
               ok_count, full_count, badpos_count, peak_len);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side, with random stalls, calm stretches and long hold-offs
   initial begin
      int stall;
      int calm_left;
      int next_hold;
      calm_left = 0;
      next_hold = 500;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_taken >= next_hold) begin
            // long hold-off so the block backs up and stalls its input
            hold_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
            next_hold += 1000;
         end else begin
            if (calm_left > 0) begin
               calm_left--;
               stall = 0;
            end else if ($urandom_range(0, 7) == 0) begin
               calm_left = $urandom_range(20, 60);
               stall = 0;
            end else begin
               stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         rsp_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles with no transaction", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_req_if.sv
rtl/ils_rsp_if.sv
rtl/ils_cell.sv
rtl/ils_row.sv
rtl/indexed_list_store.sv
rtl/ils_checker.sv
test/ils_response_checker.sv
test/tb_indexed_list_store.sv
